// File: src/hie_pkg.sv
package hie_pkg;

    localparam int DIMS   = 3;
    localparam int LEVELS = 21;
    localparam int KEY_W  = 63;
    localparam int ROT_W  = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int JMP_W  = $clog2(DIMS + 1);
    localparam int SUM_W  = $clog2(2 * DIMS - 1);

    typedef logic [DIMS-1:0]   digit_t;
    typedef logic [ROT_W-1:0]  rot_t;
    typedef logic [JMP_W-1:0]  jmp_t;
    typedef logic [LEVELS-1:0] coord_t;
    typedef logic [KEY_W-1:0]  key_t;

    typedef struct packed {
        logic                 valid;
        coord_t [DIMS-1:0]    coord;
        digit_t               w;
        digit_t               tt;
        rot_t                 rot;
        key_t                 key;
    } stage_t;

    function automatic digit_t rot_left(input digit_t v, input rot_t n);
        digit_t r;
        r = v;
        for (int k = 1; k < DIMS; k++) begin
            if (n == rot_t'(k)) begin
                r = digit_t'((v << k) | (v >> (DIMS - k)));
            end
        end
        return r;
    endfunction

    function automatic digit_t rot_right(input digit_t v, input rot_t n);
        digit_t r;
        r = v;
        for (int k = 1; k < DIMS; k++) begin
            if (n == rot_t'(k)) begin
                r = digit_t'((v >> k) | (v << (DIMS - k)));
            end
        end
        return r;
    endfunction

    function automatic digit_t gray_inverse(input digit_t s);
        digit_t p;
        p[DIMS-1] = s[DIMS-1];
        for (int k = DIMS - 2; k >= 0; k--) begin
            p[k] = s[k] ^ p[k+1];
        end
        return p;
    endfunction

    function automatic jmp_t jump_of(input digit_t p);
        jmp_t j;
        j = jmp_t'(DIMS);
        for (int i = DIMS - 1; i >= 1; i--) begin
            if (p[i] != p[0]) begin
                j = jmp_t'(DIMS - i);
            end
        end
        return j;
    endfunction

    function automatic digit_t entry_code(input digit_t p);
        digit_t q;
        q = p[0] ? (p - digit_t'(1)) : (p - digit_t'(2));
        if (p < digit_t'(3)) begin
            return '0;
        end
        return q ^ (q >> 1);
    endfunction

endpackage

// File: src/hilbert_index_encode.sv
// hilbert key encoder for 3-d points, 21 bits per coordinate
// input channel s_*: one point per transaction, coordinates packed in s_tdata
// output channel m_*: one 63-bit hilbert key per point, in arrival order
// the datapath is a row of 21 cells, one per bit level, top level first;
// each cell folds one digit into the key and passes the running transform
// and rotation to its neighbor
// throughput: one point per cycle, the row advances every cycle it is not held
// when m_tvalid is high and m_tready low the whole row holds and s_tready
// drops; points already in flight are kept and none are lost
// reset (aresetn low, synchronous) clears every cell's valid flag, emptying
// the row; the other cell fields are not reset
module hilbert_index_encode (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // coord_x [20:0], coord_y [41:21], coord_z [62:42], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // hilbert_key [62:0], zero
);
    import hie_pkg::*;

    stage_t st [LEVELS+1];
    logic   en;

    assign en       = m_tready || !st[LEVELS].valid;
    assign s_tready = en;

    always_comb begin
        st[0].valid = s_tvalid;
        for (int j = 0; j < DIMS; j++) begin
            st[0].coord[j] = s_tdata[j*LEVELS +: LEVELS];
        end
        st[0].w   = '0;
        st[0].tt  = '0;
        st[0].rot = '0;
        st[0].key = '0;
    end

    for (genvar k = 0; k < LEVELS; k++) begin : g_cell
        hie_cell #(
            .LVL (LEVELS - 1 - k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .st_i    (st[k]),
            .st_o    (st[k+1])
        );
    end

    assign m_tvalid = st[LEVELS].valid;
    assign m_tdata  = {{(64 - KEY_W){1'b0}}, st[LEVELS].key};

endmodule

// File: src/hie_cell.sv
module hie_cell #(
    parameter int LVL = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  hie_pkg::stage_t st_i,
    output hie_pkg::stage_t st_o
);
    import hie_pkg::*;

    localparam int SH = LVL * DIMS;

    digit_t          a;
    digit_t          w_next;
    digit_t          s;
    digit_t          p;
    logic [SUM_W-1:0] sum;
    stage_t          st_next;
    stage_t          st_reg;

    always_comb begin
        for (int j = 0; j < DIMS; j++) begin
            a[DIMS-1-j] = st_i.coord[j][LVL];
        end
        w_next = st_i.w ^ st_i.tt;
        s      = rot_left(a ^ w_next, st_i.rot);
        p      = gray_inverse(s);
        sum    = SUM_W'(st_i.rot) + SUM_W'(jump_of(p)) - SUM_W'(1);
        if (sum >= SUM_W'(DIMS)) begin
            sum = sum - SUM_W'(DIMS);
        end

        st_next       = st_i;
        st_next.w     = w_next;
        st_next.tt    = rot_right(entry_code(p), st_i.rot);
        st_next.rot   = rot_t'(sum);
        for (int b = 0; b < DIMS; b++) begin
            if (SH + b < KEY_W) begin
                st_next.key[SH+b] = st_i.key[SH+b] | p[b];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (en) begin
            st_reg.valid <= st_next.valid;
        end
        if (en) begin
            st_reg.coord <= st_next.coord;
            st_reg.w     <= st_next.w;
            st_reg.tt    <= st_next.tt;
            st_reg.rot   <= st_next.rot;
            st_reg.key   <= st_next.key;
        end
    end

    assign st_o = st_reg;

endmodule

// File: src/hie_checker.sv
module hie_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[63])
        else $error("key padding bit set");

    a_free_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind hilbert_index_encode hie_checker u_hie_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
